FILE: rtl/tkct_pkg.sv
package tkct_pkg;

   // Table geometry.
   localparam int ENTRIES   = 8;
   localparam int KEY_BITS  = 16;
   localparam int SLOT_BITS = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;

   // Field widths of the channels.
   localparam int KIND_W     = 2;
   localparam int KEY_W      = 16;
   localparam int CODE_W     = 16;
   localparam int SLOT_W     = 3;
   localparam int STORE_CODE_W = 15;

   // Transaction kinds.
   typedef enum logic [KIND_W-1:0] {
      KIND_SET_BASE = 2'd0,
      KIND_SET_OVER = 2'd1,
      KIND_LOOKUP   = 2'd2,
      KIND_CLEAR    = 2'd3
   } kind_type;

   typedef logic [KEY_BITS-1:0]     tkey_type;
   typedef logic [STORE_CODE_W-1:0] tcode_type;
   typedef logic [SLOT_BITS-1:0]    slot_idx_type;

   typedef tkey_type  key_array_type  [ENTRIES];
   typedef tcode_type code_array_type [ENTRIES];

   // Outcome of one slot search over one table.
   typedef struct packed {
      logic         hit;
      slot_idx_type hit_idx;
      logic         empty;
      slot_idx_type empty_idx;
   } search_type;

endpackage

FILE: rtl/tkct_if.sv
interface tkct_req_if import tkct_pkg::*; ();
   logic                     valid;
   logic                     ready;
   logic [KIND_W-1:0]        kind;
   logic [KEY_W-1:0]         key;
   logic signed [CODE_W-1:0] code;

   modport source (output valid, output kind, output key, output code, input ready);
   modport sink   (input valid, input kind, input key, input code, output ready);
endinterface

interface tkct_rsp_if import tkct_pkg::*; ();
   logic                     valid;
   logic                     ready;
   logic                     found;
   logic signed [CODE_W-1:0] code_out;
   logic [SLOT_W-1:0]        slot;
   logic                     table_full;

   modport source (output valid, output found, output code_out, output slot,
                   output table_full, input ready);
   modport sink   (input valid, input found, input code_out, input slot,
                   input table_full, output ready);
endinterface

FILE: rtl/two_level_key_code_table_core.sv
// Channel   Direction  Role
// req_ch    in         kind, key and code of one transaction
// rsp_ch    out        found, code_out, slot and table_full of its result
//
// One transaction is accepted every cycle while no result stalls. It is held
// in the input register while the key search over both tables, which sets
// the rate, runs combinationally into the result register. The result is
// therefore valid once it has passed the input register and the result
// register. The tables are written at the edge that loads the result
// register, so the next transaction sees them updated. Reset clears both
// tables and all valid flags at once. A stalled result holds both stages;
// input is still taken while the input register is free.
module two_level_key_code_table_core
   import tkct_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   tkct_req_if.sink    req_ch,
   tkct_rsp_if.source  rsp_ch
);

   // Input register.
   logic          in_valid_ff;
   kind_type      in_kind_ff;
   tkey_type      in_key_ff;
   logic          in_neg_ff;
   tcode_type     in_code_ff;

   // Result register.
   logic                     rsp_valid_ff;
   logic                     rsp_found_ff,    rsp_found_in;
   logic signed [CODE_W-1:0] rsp_code_ff,     rsp_code_in;
   logic [SLOT_W-1:0]        rsp_slot_ff,     rsp_slot_in;
   logic                     rsp_full_ff,     rsp_full_in;

   // Tables.
   key_array_type  base_keys_ff, over_keys_ff;
   code_array_type base_codes_ff, over_codes_ff;

   search_type base_srch, over_srch, set_srch;
   logic       advance;
   logic       set_write;
   logic       set_is_base;
   slot_idx_type set_idx;

   // Highest-index match, lowest-index empty slot.
   function automatic search_type search_table(key_array_type keys, tkey_type key);
      search_type res;
      res = '0;
      for (int i = 0; i < ENTRIES; i++) begin
         if (keys[i] == key) begin
            res.hit     = 1'b1;
            res.hit_idx = SLOT_BITS'(i);
         end
      end
      for (int i = ENTRIES - 1; i >= 0; i--) begin
         if (keys[i] == '0) begin
            res.empty     = 1'b1;
            res.empty_idx = SLOT_BITS'(i);
         end
      end
      return res;
   endfunction

   // Handshake: the input stage moves on when the result register is free or its result is taken.
   assign advance      = in_valid_ff && (!rsp_valid_ff || rsp_ch.ready);
   assign req_ch.ready = !in_valid_ff || advance;

   // Search both tables for the registered key.
   assign base_srch = search_table(base_keys_ff, in_key_ff);
   assign over_srch = search_table(over_keys_ff, in_key_ff);

   assign set_is_base = (in_kind_ff == KIND_SET_BASE);
   assign set_srch    = set_is_base ? base_srch : over_srch;
   assign set_idx     = set_srch.hit ? set_srch.hit_idx : set_srch.empty_idx;

   // Result of the transaction in the input register.
   always_comb begin
      rsp_found_in = 1'b0;
      rsp_code_in  = '0;
      rsp_slot_in  = '0;
      rsp_full_in  = 1'b0;
      set_write    = 1'b0;
      unique case (in_kind_ff)
         KIND_SET_BASE, KIND_SET_OVER: begin
            if (set_srch.hit || set_srch.empty) begin
               rsp_found_in = 1'b1;
               rsp_slot_in  = SLOT_W'(set_idx);
               set_write    = 1'b1;
            end else begin
               rsp_full_in = 1'b1;
            end
         end
         KIND_LOOKUP: begin
            if (over_srch.hit) begin
               rsp_found_in = 1'b1;
               rsp_code_in  = {1'b0, over_codes_ff[over_srch.hit_idx]};
               rsp_slot_in  = SLOT_W'(over_srch.hit_idx);
            end else if (base_srch.hit) begin
               rsp_found_in = 1'b1;
               rsp_code_in  = {1'b0, base_codes_ff[base_srch.hit_idx]};
               rsp_slot_in  = SLOT_W'(base_srch.hit_idx);
            end else begin
               rsp_code_in = '1;
            end
         end
         KIND_CLEAR: begin
         end
         default: begin
         end
      endcase
   end

   // Input register load.
   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else if (req_ch.ready) begin
         in_valid_ff <= req_ch.valid;
      end
      if (req_ch.valid && req_ch.ready) begin
         in_kind_ff <= kind_type'(req_ch.kind);
         in_key_ff  <= KEY_BITS'(req_ch.key);
         in_neg_ff  <= req_ch.code[CODE_W-1];
         in_code_ff <= req_ch.code[STORE_CODE_W-1:0];
      end
   end

   // Result register.
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (advance) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_ch.ready) begin
         rsp_valid_ff <= 1'b0;
      end
      if (advance) begin
         rsp_found_ff <= rsp_found_in;
         rsp_code_ff  <= rsp_code_in;
         rsp_slot_ff  <= rsp_slot_in;
         rsp_full_ff  <= rsp_full_in;
      end
   end

   // Table updates: set writes or removes one slot, clear zeroes all keys.
   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < ENTRIES; i++) begin
            base_keys_ff[i]  <= '0;
            base_codes_ff[i] <= '0;
            over_keys_ff[i]  <= '0;
            over_codes_ff[i] <= '0;
         end
      end else if (advance) begin
         if (set_write && set_is_base) begin
            base_keys_ff[set_idx]  <= in_neg_ff ? '0 : in_key_ff;
            base_codes_ff[set_idx] <= in_neg_ff ? '0 : in_code_ff;
         end
         if (set_write && !set_is_base) begin
            over_keys_ff[set_idx]  <= in_neg_ff ? '0 : in_key_ff;
            over_codes_ff[set_idx] <= in_neg_ff ? '0 : in_code_ff;
         end
         if (in_kind_ff == KIND_CLEAR) begin
            for (int i = 0; i < ENTRIES; i++) begin
               base_keys_ff[i] <= '0;
               over_keys_ff[i] <= '0;
            end
         end
      end
   end

   assign rsp_ch.valid      = rsp_valid_ff;
   assign rsp_ch.found      = rsp_found_ff;
   assign rsp_ch.code_out   = rsp_code_ff;
   assign rsp_ch.slot       = rsp_slot_ff;
   assign rsp_ch.table_full = rsp_full_ff;

endmodule

FILE: sim/two_level_key_code_table_core_tb.sv
`timescale 1ns / 100ps

module two_level_key_code_table_core_tb
   import tkct_pkg::*;
();

   localparam int CYCLE_LIMIT = 200000;
   localparam int POOL_SIZE   = 10;
   localparam int RANDOM_ITEMS = 400;

   // One result transaction as the table should report it.
   typedef struct {
      logic              found;
      logic [CODE_W-1:0] code_out;
      logic [SLOT_W-1:0] slot;
      logic              table_full;
   } table_result_type;

   // Mirror of both tables and the queue of results still owed by the block.
   class code_table_model;
      tkey_type         keys  [2][ENTRIES];
      tcode_type        codes [2][ENTRIES];
      table_result_type expected_results[$];
      int               faults;
      int               reported;

      function new();
         for (int t = 0; t < 2; t++) begin
            for (int i = 0; i < ENTRIES; i++) begin
               keys[t][i]  = '0;
               codes[t][i] = '0;
            end
         end
         faults   = 0;
         reported = 0;
      endfunction

      // Highest-index matching slot, else lowest-index empty slot, else -1.
      function int find_slot(int t, tkey_type key);
         int empty_slot;
         empty_slot = -1;
         for (int i = ENTRIES - 1; i >= 0; i--) begin
            if (keys[t][i] == key) return i;
            if (keys[t][i] == '0) empty_slot = i;
         end
         return empty_slot;
      endfunction

      function int pending();
         return expected_results.size();
      endfunction

      // Apply one accepted request to the mirror and queue its result.
      function void note_request(kind_type kind, tkey_type key, logic [CODE_W-1:0] code);
         table_result_type r;
         int t;
         int s;
         r.found      = 1'b0;
         r.code_out   = '0;
         r.slot       = '0;
         r.table_full = 1'b0;
         case (kind)
            KIND_SET_BASE, KIND_SET_OVER: begin
               t = (kind == KIND_SET_OVER) ? 1 : 0;
               s = find_slot(t, key);
               if (s < 0) begin
                  r.table_full = 1'b1;
               end else begin
                  if (code[CODE_W-1]) begin
                     keys[t][s]  = '0;
                     codes[t][s] = '0;
                  end else begin
                     keys[t][s]  = key;
                     codes[t][s] = code[STORE_CODE_W-1:0];
                  end
                  r.found = 1'b1;
                  r.slot  = s[SLOT_W-1:0];
               end
            end
            KIND_LOOKUP: begin
               // Override is searched first; a miss in both reports -1.
               r.code_out = '1;
               for (t = 1; t >= 0 && !r.found; t--) begin
                  s = find_slot(t, key);
                  if (s >= 0 && keys[t][s] == key) begin
                     r.found    = 1'b1;
                     r.code_out = {1'b0, codes[t][s]};
                     r.slot     = s[SLOT_W-1:0];
                  end
               end
            end
            KIND_CLEAR: begin
               for (t = 0; t < 2; t++) begin
                  for (int i = 0; i < ENTRIES; i++) keys[t][i] = '0;
               end
            end
         endcase
         expected_results.push_back(r);
      endfunction

      // Compare one accepted result with the oldest expectation.
      function void check_result(logic found, logic [CODE_W-1:0] code_out,
                                 logic [SLOT_W-1:0] slot, logic table_full);
         table_result_type e;
         if (expected_results.size() == 0) begin
            faults++;
            if (reported < 10) begin
               reported++;
               $display("Unexpected result: found=%0b code_out=%h slot=%0d table_full=%0b",
                        found, code_out, slot, table_full);
            end
            return;
         end
         e = expected_results.pop_front();
         if (found !== e.found || code_out !== e.code_out || slot !== e.slot ||
             table_full !== e.table_full) begin
            faults++;
            if (reported < 10) begin
               reported++;
               $display("Mismatch: expected found=%0b code_out=%h slot=%0d table_full=%0b",
                        e.found, e.code_out, e.slot, e.table_full);
               $display("          actual   found=%0b code_out=%h slot=%0d table_full=%0b",
                        found, code_out, slot, table_full);
            end
         end
      endfunction
   endclass

   logic clock = 1'b0;
   logic reset = 1'b1;

   tkct_req_if req_if ();
   tkct_rsp_if rsp_if ();

   two_level_key_code_table_core dut (
      .clock  (clock),
      .reset  (reset),
      .req_ch (req_if),
      .rsp_ch (rsp_if)
   );

   code_table_model model = new();

   int cycle_count   = 0;
   int send_calm     = 0;
   int recv_calm     = 0;
   int rx_hold_cycles = 0;
   tkey_type key_pool [POOL_SIZE];

   always #10 clock = ~clock;

   // Watchdog on the total run length.
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("TB_ERROR");
         $finish;
      end
   end

   // Idle length per transaction, with occasional stretches of no idling.
   function automatic int draw_idle(inout int calm_left);
      if (calm_left > 0) begin
         calm_left--;
         return 0;
      end
      if ($urandom_range(0, 15) == 0) begin
         calm_left = $urandom_range(10, 40);
         return 0;
      end
      return $urandom_range(0, 19);
   endfunction

   // Offer one request transaction and wait for it to be taken.
   task automatic send_item(kind_type kind, tkey_type key, logic [CODE_W-1:0] code);
      int gap;
      gap = draw_idle(send_calm);
      if (gap > 0) begin
         req_if.valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_if.valid <= 1'b1;
      req_if.kind  <= kind;
      req_if.key   <= key;
      req_if.code  <= code;
      do @(posedge clock); while (req_if.ready !== 1'b1);
      model.note_request(kind, key, code);
   endtask

   // Stop offering until every queued result has come back.
   task automatic drain_results();
      req_if.valid <= 1'b0;
      do @(posedge clock); while (model.pending() != 0);
   endtask

   // Receiver: random back-pressure, one long hold when requested.
   initial begin
      int wait_cycles;
      rsp_if.ready <= 1'b0;
      forever begin
         if (rx_hold_cycles > 0) begin
            wait_cycles    = rx_hold_cycles;
            rx_hold_cycles = 0;
         end else begin
            wait_cycles = draw_idle(recv_calm);
         end
         if (wait_cycles > 0) begin
            rsp_if.ready <= 1'b0;
            repeat (wait_cycles) @(posedge clock);
         end
         rsp_if.ready <= 1'b1;
         do @(posedge clock); while (rsp_if.valid !== 1'b1);
         model.check_result(rsp_if.found, rsp_if.code_out, rsp_if.slot,
                            rsp_if.table_full);
      end
   end

   // Main sequence: reset, directed cases, random traffic, then drain.
   initial begin
      kind_type          kind;
      tkey_type          key;
      logic [CODE_W-1:0] code;
      int                pick;

      req_if.valid <= 1'b0;
      req_if.kind  <= KIND_SET_BASE;
      req_if.key   <= '0;
      req_if.code  <= '0;
      repeat (4) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Key zero on empty tables matches the highest empty override slot.
      send_item(KIND_LOOKUP,   16'h0000, 16'h0000);
      send_item(KIND_SET_BASE, 16'hFFFF, 16'h7FFF);
      send_item(KIND_LOOKUP,   16'hFFFF, 16'h0000);
      // Override shadows base, and its removal uncovers base again.
      send_item(KIND_SET_OVER, 16'hFFFF, 16'h0000);
      send_item(KIND_LOOKUP,   16'hFFFF, 16'h0000);
      send_item(KIND_SET_OVER, 16'hFFFF, 16'hFFFF);
      send_item(KIND_LOOKUP,   16'hFFFF, 16'h0000);
      // Fill the base table, then try to add to it.
      for (int i = 0; i < ENTRIES - 1; i++)
         send_item(KIND_SET_BASE, tkey_type'(1 << i), CODE_W'(100 * i + 1));
      send_item(KIND_SET_BASE, 16'h1234, 16'h0005);
      send_item(KIND_SET_BASE, 16'h0000, 16'h0009);
      send_item(KIND_LOOKUP,   16'h5555, 16'h0000);
      // Clear keeps the codes; key zero then matches the highest override slot.
      send_item(KIND_CLEAR,    16'hFFFF, 16'hFFFF);
      send_item(KIND_LOOKUP,   16'h0000, 16'h0000);
      send_item(KIND_SET_BASE, 16'h0000, 16'h0064);
      send_item(KIND_SET_OVER, 16'h8000, 16'h0001);
      send_item(KIND_LOOKUP,   16'h8000, 16'h0000);
      // Removal of a key that is absent empties the lowest free slot.
      send_item(KIND_SET_BASE, 16'h0001, 16'hFFFF);
      send_item(KIND_CLEAR,    16'h0000, 16'h0000);

      // A small key pool keeps matches and full tables frequent.
      for (int i = 0; i < POOL_SIZE; i++) key_pool[i] = tkey_type'($urandom_range(1, 65535));

      for (int n = 0; n < RANDOM_ITEMS; n++) begin
         if (n == 100) begin
            // Long receiver hold while the sender keeps pushing.
            rx_hold_cycles = 300;
            send_calm      = 40;
         end
         if (n == 250) drain_results();

         pick = $urandom_range(0, 99);
         if (pick < 35)      kind = KIND_SET_BASE;
         else if (pick < 65) kind = KIND_SET_OVER;
         else if (pick < 95) kind = KIND_LOOKUP;
         else                kind = KIND_CLEAR;

         pick = $urandom_range(0, 99);
         if (pick < 70)      key = key_pool[$urandom_range(0, POOL_SIZE - 1)];
         else if (pick < 80) key = '0;
         else                key = tkey_type'($urandom_range(0, 65535));

         if ($urandom_range(0, 99) < 15) code = '1;
         else                            code = CODE_W'($urandom_range(0, 32767));

         send_item(kind, key, code);
      end

      req_if.valid <= 1'b0;
      while (model.pending() != 0) @(posedge clock);
      repeat (20) @(posedge clock);

      if (model.faults == 0 && model.pending() == 0) begin
         $display("TB_OK");
      end else begin
         $display("TB_ERROR");
      end
      $finish;
   end

endmodule
